@@ rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// operation and status codes and divider flags shared by the complex arithmetic unit files
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SAT  = 2'd1,
    STAT_DIV0 = 2'd2
  } status_e;

  typedef struct packed {
    logic ovf_re;
    logic ovf_im;
  } div_flags_t;

endpackage

@@ rtl/complex_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// path: every operation passes stage 1, stage 2, the divider and the output register to valid_o
// throughput: one item per cycle, the whole pipeline holds while the output
// register is full and stalled
// reset: rst_ni clears all valid bits asynchronously, payload is not reset
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [1:0]                   func_i,
  input  logic signed [DATA_WIDTH-1:0] a_real_i,
  input  logic signed [DATA_WIDTH-1:0] a_imag_i,
  input  logic signed [DATA_WIDTH-1:0] b_real_i,
  input  logic signed [DATA_WIDTH-1:0] b_imag_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic signed [DATA_WIDTH-1:0] res_real_o,
  output logic signed [DATA_WIDTH-1:0] res_imag_o,
  output logic [1:0]                   status_o
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW + 1;
  localparam int SW = 2 * PW + 5;
  localparam logic signed [PW-1:0] POS_LIM = (PW'(1) << (DW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] NEG_LIM = -POS_LIM - PW'(1);
  localparam logic [DW-1:0] Q_POS = (DW'(1) << (DW - 1)) - DW'(1);
  localparam logic [DW-1:0] Q_NEG = DW'(1) << (DW - 1);

  logic en;
  logic out_v_q;

  assign en      = !out_v_q || !stall_i;
  assign stall_o = !en;

  // stage 1: products and sums
  logic                   v1_q;
  logic [1:0]             func1_q;
  logic signed [2*DW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, d_r_q, d_i_q;
  logic signed [DW:0]     s_re_q, s_im_q;
  logic signed [DW:0]     ar_x, ai_x, br_x, bi_x;

  assign ar_x = {a_real_i[DW-1], a_real_i};
  assign ai_x = {a_imag_i[DW-1], a_imag_i};
  assign br_x = {b_real_i[DW-1], b_real_i};
  assign bi_x = {b_imag_i[DW-1], b_imag_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func1_q <= func_i;
      p_rr_q  <= a_real_i * b_real_i;
      p_ii_q  <= a_imag_i * b_imag_i;
      p_ri_q  <= a_real_i * b_imag_i;
      p_ir_q  <= a_imag_i * b_real_i;
      d_r_q   <= b_real_i * b_real_i;
      d_i_q   <= b_imag_i * b_imag_i;
      s_re_q  <= (func_i == FUNC_SUB) ? ar_x - br_x : ar_x + br_x;
      s_im_q  <= (func_i == FUNC_SUB) ? ai_x - bi_x : ai_x + bi_x;
    end
  end

  // stage 2: combine products, or pass the sums for add and sub, and sum the divisor
  logic                   v2_q;
  logic [1:0]             func2_q;
  logic signed [PW-1:0]   num_re_q, num_im_q, num_re_d, num_im_d;
  logic [2*DW-1:0]        den_q;

  always_comb begin
    case (func1_q)
      FUNC_MUL: begin
        num_re_d = PW'(p_rr_q) - PW'(p_ii_q);
        num_im_d = PW'(p_ri_q) + PW'(p_ir_q);
      end
      FUNC_DIV: begin
        num_re_d = PW'(p_rr_q) + PW'(p_ii_q);
        num_im_d = PW'(p_ir_q) - PW'(p_ri_q);
      end
      default: begin
        num_re_d = PW'(s_re_q);
        num_im_d = PW'(s_im_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func2_q  <= func1_q;
      num_re_q <= num_re_d;
      num_im_q <= num_im_d;
      den_q    <= unsigned'(d_r_q) + unsigned'(d_i_q);
    end
  end

  // into the divider: magnitudes plus sideband for the other operations
  logic                 is_mul2, is_div2;
  logic signed [PW-1:0] val_re, val_im;
  logic [PW-1:0]        mag_re, mag_im;
  logic [SW-1:0]        side_in, side_out;
  logic                 div_v;
  logic [DW-1:0]        q_re, q_im;
  div_flags_t           flags;

  assign is_mul2 = func2_q == FUNC_MUL;
  assign is_div2 = func2_q == FUNC_DIV;
  assign val_re  = is_mul2 ? (num_re_q >>> FRAC_BITS) : num_re_q;
  assign val_im  = is_mul2 ? (num_im_q >>> FRAC_BITS) : num_im_q;
  assign mag_re  = num_re_q[PW-1] ? unsigned'(-num_re_q) : unsigned'(num_re_q);
  assign mag_im  = num_im_q[PW-1] ? unsigned'(-num_im_q) : unsigned'(num_im_q);
  assign side_in = {is_div2, num_re_q[PW-1], num_im_q[PW-1],
                    is_div2 && (den_q == '0), 1'b0, val_re, val_im};

  cau_divider #(
    .DATA_WIDTH (DW),
    .FRAC_BITS  (FRAC_BITS),
    .SIDE_WIDTH (SW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v2_q),
    .num_re_i (mag_re[2*DW-1:0]),
    .num_im_i (mag_im[2*DW-1:0]),
    .den_i    (den_q),
    .side_i   (side_in),
    .valid_o  (div_v),
    .q_re_o   (q_re),
    .q_im_o   (q_im),
    .flags_o  (flags),
    .side_o   (side_out)
  );

  function automatic logic [DW:0] sat_val(input logic signed [PW-1:0] x);
    logic [DW:0] r;
    if (x > POS_LIM) begin
      r = {1'b1, POS_LIM[DW-1:0]};
    end else if (x < NEG_LIM) begin
      r = {1'b1, NEG_LIM[DW-1:0]};
    end else begin
      r = {1'b0, x[DW-1:0]};
    end
    return r;
  endfunction

  function automatic logic [DW:0] sat_quo(input logic neg, input logic ovf,
                                          input logic [DW-1:0] q);
    logic [DW:0] r;
    if (neg && (ovf || q != '0)) begin
      if (ovf || q > Q_NEG) begin
        r = {1'b1, Q_NEG};
      end else begin
        r = {1'b0, -q};
      end
    end else if (ovf || q > Q_POS) begin
      r = {1'b1, Q_POS};
    end else begin
      r = {1'b0, q};
    end
    return r;
  endfunction

  // output register
  logic                 o_div, o_neg_re, o_neg_im, o_div0, o_unused;
  logic signed [PW-1:0] o_val_re, o_val_im;
  logic [DW:0]          fin_re, fin_im;
  logic signed [DW-1:0] res_re_q, res_im_q;
  logic [1:0]           status_q, status_d;

  assign {o_div, o_neg_re, o_neg_im, o_div0, o_unused, o_val_re, o_val_im} = side_out;
  assign fin_re = o_div ? sat_quo(o_neg_re, flags.ovf_re, q_re) : sat_val(o_val_re);
  assign fin_im = o_div ? sat_quo(o_neg_im, flags.ovf_im, q_im) : sat_val(o_val_im);

  always_comb begin
    if (o_div0) begin
      status_d = STAT_DIV0;
    end else if (fin_re[DW] || fin_im[DW] || o_unused) begin
      status_d = STAT_SAT;
    end else begin
      status_d = STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= o_div0 ? '0 : fin_re[DW-1:0];
      res_im_q <= o_div0 ? '0 : fin_im[DW-1:0];
      status_q <= status_d;
    end
  end

  assign valid_o    = out_v_q;
  assign res_real_o = res_re_q;
  assign res_imag_o = res_im_q;
  assign status_o   = status_q;

endmodule

@@ rtl/cau_divider.sv @@
// ----------------------------------------------------------------------------
// cau_divider
// pipelined restoring divider, one quotient bit per stage for both parts,
// computes (num << FRAC_BITS) / den with an overflow flag per part
// ----------------------------------------------------------------------------
module cau_divider #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8,
  parameter int SIDE_WIDTH = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2*DATA_WIDTH-1:0] num_re_i,
  input  logic [2*DATA_WIDTH-1:0] num_im_i,
  input  logic [2*DATA_WIDTH-1:0] den_i,
  input  logic [SIDE_WIDTH-1:0]   side_i,
  output logic                    valid_o,
  output logic [DATA_WIDTH-1:0]   q_re_o,
  output logic [DATA_WIDTH-1:0]   q_im_o,
  output cau_pkg::div_flags_t     flags_o,
  output logic [SIDE_WIDTH-1:0]   side_o
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int NW = 2 * DW + FRAC_BITS;
  localparam int CW = 3 * DW + FRAC_BITS;

  logic                  v_q    [DW+1];
  logic [NW-1:0]         rre_q  [DW+1];
  logic [NW-1:0]         rim_q  [DW+1];
  logic [DW-1:0]         qre_q  [DW+1];
  logic [DW-1:0]         qim_q  [DW+1];
  logic [2*DW-1:0]       den_q  [DW+1];
  div_flags_t            flg_q  [DW+1];
  logic [SIDE_WIDTH-1:0] side_q [DW+1];

  logic [NW-1:0] nre_d, nim_d;
  logic [CW-1:0] den_top;

  assign nre_d   = NW'(num_re_i) << FRAC_BITS;
  assign nim_d   = NW'(num_im_i) << FRAC_BITS;
  assign den_top = CW'(den_i) << DW;

  // first stage: shift numerators and check for a quotient of DW+1 bits or more
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rre_q[0]         <= nre_d;
      rim_q[0]         <= nim_d;
      qre_q[0]         <= '0;
      qim_q[0]         <= '0;
      den_q[0]         <= den_i;
      flg_q[0].ovf_re  <= CW'(nre_d) >= den_top;
      flg_q[0].ovf_im  <= CW'(nim_d) >= den_top;
      side_q[0]        <= side_i;
    end
  end

  for (genvar j = 1; j <= DW; j++) begin : g_stage
    localparam int K = DW - j;
    logic [CW-1:0] dsh;
    logic          take_re, take_im;

    assign dsh     = CW'(den_q[j-1]) << K;
    assign take_re = CW'(rre_q[j-1]) >= dsh;
    assign take_im = CW'(rim_q[j-1]) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rre_q[j]  <= take_re ? rre_q[j-1] - NW'(dsh) : rre_q[j-1];
        rim_q[j]  <= take_im ? rim_q[j-1] - NW'(dsh) : rim_q[j-1];
        qre_q[j]  <= qre_q[j-1] | (DW'(take_re) << K);
        qim_q[j]  <= qim_q[j-1] | (DW'(take_im) << K);
        den_q[j]  <= den_q[j-1];
        flg_q[j]  <= flg_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o = v_q[DW];
  assign q_re_o  = qre_q[DW];
  assign q_im_o  = qim_q[DW];
  assign flags_o = flg_q[DW];
  assign side_o  = side_q[DW];

endmodule

@@ rtl/cau_checker.sv @@
// ----------------------------------------------------------------------------
// cau_checker
// port-level assertions for the complex arithmetic unit, bound to the top
// ----------------------------------------------------------------------------
module cau_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  valid_i,
  input logic                  stall_o,
  input logic [1:0]            func_i,
  input logic [DATA_WIDTH-1:0] a_real_i,
  input logic [DATA_WIDTH-1:0] a_imag_i,
  input logic [DATA_WIDTH-1:0] b_real_i,
  input logic [DATA_WIDTH-1:0] b_imag_i,
  input logic                  valid_o,
  input logic                  stall_i,
  input logic [DATA_WIDTH-1:0] res_real_o,
  input logic [DATA_WIDTH-1:0] res_imag_o,
  input logic [1:0]            status_o
);
  import cau_pkg::*;

  // stall only from a full, stalled output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("stall without stalled output");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && stall_o) |=> (valid_i && $stable(func_i)
                              && $stable(a_real_i) && $stable(a_imag_i)
                              && $stable(b_real_i) && $stable(b_imag_i)))
    else $error("stalled input item changed");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(res_real_o)
                              && $stable(res_imag_o) && $stable(status_o)))
    else $error("stalled item changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == STAT_OK || status_o == STAT_SAT
                 || status_o == STAT_DIV0))
    else $error("bad status");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STAT_DIV0) |-> (res_real_o == '0 && res_imag_o == '0))
    else $error("divide by zero with nonzero result");

endmodule

bind complex_arithmetic_unit_top cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);
